FILE: src/dfed_pkg.sv
// shared constants and types for the delimited frame echo deframer
`default_nettype none
package dfed_pkg;

  localparam int MAX_FRAME = 10;
  localparam int FILL_W    = $clog2(MAX_FRAME + 1);
  localparam int IDX_W     = $clog2(MAX_FRAME);
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_TAIL_FIRST    = 2'd2;
  localparam logic [1:0] REG_TAIL_SECOND   = 2'd3;

  localparam logic [7:0] RST_HEADER_FIRST  = 8'h3A;
  localparam logic [7:0] RST_HEADER_SECOND = 8'h3B;
  localparam logic [7:0] RST_TAIL_FIRST    = 8'h7E;
  localparam logic [7:0] RST_TAIL_SECOND   = 8'h7F;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] tail_first;
    logic [7:0] tail_second;
  } dfed_cfg_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic              emit;
    logic [FILL_W-1:0] emit_len;
  } dfed_ctrl_t;

endpackage
`default_nettype wire

FILE: src/dfed_cell.sv
// one byte cell of the frame store chain
`default_nettype none
module dfed_cell (
  input  wire logic       clk,
  input  wire logic       load,
  input  wire logic [7:0] load_data,
  input  wire logic       shift,
  input  wire logic [7:0] shift_in,
  output logic [7:0]      q
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  always_comb begin
    priority if (load) begin
      data_nxt = load_data;
    end else if (shift) begin
      data_nxt = shift_in;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule
`default_nettype wire

FILE: src/dfed_hunt.sv
// header and tail hunting state machine
`default_nettype none
module dfed_hunt (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [7:0]          rx_byte,
  input  wire dfed_pkg::dfed_cfg_t cfg,
  output dfed_pkg::dfed_ctrl_t     ctrl
);
  import dfed_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HDR1 = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  logic [1:0]        phase_r, phase_nxt;
  logic              tail_pend_r, tail_pend_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              emit;

  always_comb begin
    phase_nxt     = phase_r;
    tail_pend_nxt = tail_pend_r;
    fill_nxt      = fill_r;
    emit          = 1'b0;
    if (accept) begin
      unique case (phase_r)
        PH_BODY: begin
          if (tail_pend_r) begin
            if (rx_byte == cfg.tail_second) begin
              emit          = 1'b1;
              phase_nxt     = PH_IDLE;
              tail_pend_nxt = 1'b0;
              fill_nxt      = '0;
            end else begin
              tail_pend_nxt = 1'b0;
              fill_nxt      = fill_r + FILL_W'(1);
            end
          end else begin
            if (rx_byte == cfg.tail_first) begin
              tail_pend_nxt = 1'b1;
            end
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
        PH_HDR1: begin
          if (rx_byte == cfg.header_second) begin
            phase_nxt = PH_BODY;
            fill_nxt  = fill_r + FILL_W'(1);
          end else begin
            phase_nxt     = PH_IDLE;
            tail_pend_nxt = 1'b0;
            fill_nxt      = '0;
          end
        end
        default: begin
          if (rx_byte == cfg.header_first) begin
            phase_nxt = PH_HDR1;
            fill_nxt  = FILL_W'(1);
          end else begin
            phase_nxt     = PH_IDLE;
            tail_pend_nxt = 1'b0;
            fill_nxt      = '0;
          end
        end
      endcase
      // length limit reached: drop the frame
      if (fill_nxt >= FILL_W'(MAX_FRAME)) begin
        phase_nxt     = PH_IDLE;
        tail_pend_nxt = 1'b0;
        fill_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tail_pend_r <= 1'b0;
      fill_r      <= '0;
    end else begin
      phase_r     <= phase_nxt;
      tail_pend_r <= tail_pend_nxt;
      fill_r      <= fill_nxt;
    end
  end

  always_comb begin
    ctrl.wr_en    = accept;
    ctrl.wr_idx   = fill_r[IDX_W-1:0];
    ctrl.emit     = emit;
    ctrl.emit_len = fill_r + FILL_W'(1);
  end

endmodule
`default_nettype wire

FILE: src/delimited_frame_echo_deframer_unit.sv
// top level of the delimited frame echo deframer
// closing tail byte loads the echo counter; first byte then goes to the output register
// an n-byte frame leaves the cell chain one byte per cycle while out_stall is low
// input is stalled while a frame is echoed; otherwise one byte per cycle is taken
// synchronous active-low reset returns to hunting and restores the delimiter registers
// the frame store cells are not reset
`default_nettype none
module delimited_frame_echo_deframer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_tx_byte,
  output logic                               out_frame_end,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dfed_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [dfed_pkg::DATA_W-1:0]   pwdata,
  output logic [dfed_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import dfed_pkg::*;

  dfed_cfg_t         cfg_r, cfg_nxt;
  dfed_ctrl_t        ctrl;
  logic              accept;
  logic              shift_en;
  logic              out_load;
  logic [FILL_W-1:0] remain_r, remain_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_tx_byte_r;
  logic              out_frame_end_r;
  logic [7:0]        cell_q [MAX_FRAME];
  logic [1:0]        reg_idx;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_HEADER_FIRST:  cfg_nxt.header_first  = pwdata[7:0];
        REG_HEADER_SECOND: cfg_nxt.header_second = pwdata[7:0];
        REG_TAIL_FIRST:    cfg_nxt.tail_first    = pwdata[7:0];
        REG_TAIL_SECOND:   cfg_nxt.tail_second   = pwdata[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HEADER_FIRST:  prdata = {{(DATA_W-8){1'b0}}, cfg_r.header_first};
      REG_HEADER_SECOND: prdata = {{(DATA_W-8){1'b0}}, cfg_r.header_second};
      REG_TAIL_FIRST:    prdata = {{(DATA_W-8){1'b0}}, cfg_r.tail_first};
      REG_TAIL_SECOND:   prdata = {{(DATA_W-8){1'b0}}, cfg_r.tail_second};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first  <= RST_HEADER_FIRST;
      cfg_r.header_second <= RST_HEADER_SECOND;
      cfg_r.tail_first    <= RST_TAIL_FIRST;
      cfg_r.tail_second   <= RST_TAIL_SECOND;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input side
  assign in_stall = (remain_r != '0);
  assign accept   = in_valid && !in_stall;

  dfed_hunt u_hunt (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .ctrl    (ctrl)
  );

  // cell chain: written by index, drained toward cell zero
  assign out_load = !out_valid_r || !out_stall;
  assign shift_en = (remain_r != '0) && out_load;

  for (genvar gi = 0; gi < MAX_FRAME; gi++) begin : g_cell
    logic [7:0] nb;
    if (gi == MAX_FRAME - 1) begin : g_last
      assign nb = 8'h00;
    end else begin : g_mid
      assign nb = cell_q[gi+1];
    end
    dfed_cell u_cell (
      .clk       (clk),
      .load      (ctrl.wr_en && (ctrl.wr_idx == IDX_W'(gi))),
      .load_data (in_rx_byte),
      .shift     (shift_en),
      .shift_in  (nb),
      .q         (cell_q[gi])
    );
  end

  // echo counter and output register
  always_comb begin
    remain_nxt    = remain_r;
    out_valid_nxt = out_valid_r;
    priority if (ctrl.emit) begin
      remain_nxt = ctrl.emit_len;
    end else if (shift_en) begin
      remain_nxt = remain_r - FILL_W'(1);
    end
    if (out_load) begin
      out_valid_nxt = shift_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      out_tx_byte_r   <= cell_q[0];
      out_frame_end_r <= (remain_r == FILL_W'(1));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = out_tx_byte_r;
  assign out_frame_end = out_frame_end_r;

endmodule
`default_nettype wire
